// File: rtl/stpc_pkg.sv
`default_nettype none

package stpc_pkg;

   // Fixed field widths of the channels and the register
   localparam int STICK_W    = 16;
   localparam int MAX_DIFF_W = 16;
   localparam int PAIR_W     = 6;
   localparam logic [PAIR_W-1:0] PAIR_MAX = 6'd63;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_IDX_MAX_DIFF = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_DONE
   } stpc_state_type;

   typedef struct packed {
      logic accept;     // take the input transaction
      logic shift;      // one insertion step
      logic scan_init;  // clear scan state
      logic scan;       // one scan step
      logic finish;     // load the result register, clear the set
   } stpc_cmd_type;

   typedef struct packed {
      logic ins_needed;
      logic shift_done;
      logic scan_done;
      logic out_free;
   } stpc_sts_type;

endpackage

`default_nettype wire

// File: rtl/stpc_if.sv
`default_nettype none

interface stpc_req_if import stpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STICK_W-1:0] stick_length;
   logic               last_stick;

   modport source (output valid, output stick_length, output last_stick, input ready);
   modport sink (input valid, input stick_length, input last_stick, output ready);
endinterface

interface stpc_rsp_if import stpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAIR_W-1:0] pair_count;
   logic              overflow;

   modport source (output valid, output pair_count, output overflow, input ready);
   modport sink (input valid, input pair_count, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/stpc_ram.sv
`default_nettype none

module stpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/stpc_ctrl.sv
`default_nettype none

module stpc_ctrl import stpc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_last_stick,
   output logic              req_ready,
   input  wire stpc_sts_type sts,
   output stpc_cmd_type      cmd
);

   stpc_state_type state_ff, state_in;
   logic           last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last_stick;
               if (sts.ins_needed) begin
                  state_in = ST_SHIFT;
               end else if (req_last_stick) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SHIFT: begin
            if (sts.shift_done) begin
               state_in = last_ff ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.accept    = req_valid;
            cmd.scan_init = req_valid && !sts.ins_needed && req_last_stick;
         end
         ST_SHIFT: begin
            cmd.shift     = 1'b1;
            cmd.scan_init = sts.shift_done && last_ff;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/stpc_dp.sv
`default_nettype none

module stpc_dp import stpc_pkg::*; #(
   parameter int MAX_STICKS  = 64,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stpc_cmd_type          cmd,
   output stpc_sts_type               sts,
   input  wire logic [STICK_W-1:0]    req_stick_length,
   input  wire logic [MAX_DIFF_W-1:0] max_diff,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic      [PAIR_W-1:0]     rsp_pair_count,
   output logic                       rsp_overflow
);

   localparam int AW    = $clog2(MAX_STICKS);
   localparam int CNT_W = $clog2(MAX_STICKS + 1);
   localparam int CMP_W = (LENGTH_BITS > MAX_DIFF_W) ? LENGTH_BITS : MAX_DIFF_W;
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_STICKS);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [LENGTH_BITS-1:0] key_ff, key_in;
   logic [AW-1:0]          j_ff, j_in;
   logic [CNT_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   rvalid_ff, rvalid_in;
   logic [LENGTH_BITS-1:0] cur_ff, cur_in;
   logic                   have_cur_ff, have_cur_in;
   logic [PAIR_W-1:0]      pairs_ff, pairs_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PAIR_W-1:0]      rsp_pairs_ff, rsp_pairs_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [LENGTH_BITS-1:0] ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [LENGTH_BITS-1:0] ram_rdata;

   logic [LENGTH_BITS-1:0] len_cut;
   logic                   has_room;
   logic                   greater;
   logic [LENGTH_BITS-1:0] diff;
   logic                   pair_ok;

   assign len_cut  = LENGTH_BITS'(req_stick_length);
   assign has_room = (count_ff != COUNT_FULL);
   assign greater  = (ram_rdata > key_ff);
   assign diff     = ram_rdata - cur_ff;
   assign pair_ok  = have_cur_ff && (CMP_W'(diff) <= CMP_W'(max_diff));

   assign sts.ins_needed = has_room && (count_ff != '0);
   assign sts.shift_done = (j_ff == '0) || !greater;
   assign sts.scan_done  = (scan_addr_ff == count_ff) && !rvalid_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // Memory port selection: direct write of the first stick, insertion
   // shifts, the sequential scan read, and otherwise a read of the last stored stick
   always_comb begin
      ram_we    = (cmd.accept && has_room && (count_ff == '0)) || cmd.shift;
      ram_waddr = cmd.shift ? j_ff : '0;
      ram_wdata = cmd.shift ? (sts.shift_done ? key_ff : ram_rdata) : len_cut;
      priority if (cmd.scan) begin
         ram_raddr = scan_addr_ff[AW-1:0];
      end else if (cmd.shift) begin
         ram_raddr = j_ff - AW'(2);
      end else begin
         ram_raddr = count_ff[AW-1:0] - AW'(1);
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      j_in         = j_ff;
      scan_addr_in = scan_addr_ff;
      rvalid_in    = rvalid_ff;
      cur_in       = cur_ff;
      have_cur_in  = have_cur_ff;
      pairs_in     = pairs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pairs_in = rsp_pairs_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.accept) begin
         if (has_room) begin
            key_in   = len_cut;
            j_in     = count_ff[AW-1:0];
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;  // drop the stick
         end
      end

      if (cmd.shift && !sts.shift_done) begin
         j_in = j_ff - AW'(1);
      end

      if (cmd.scan_init) begin
         scan_addr_in = '0;
         rvalid_in    = 1'b0;
         have_cur_in  = 1'b0;
         pairs_in     = '0;
      end

      if (cmd.scan) begin
         if (scan_addr_ff != count_ff) begin
            scan_addr_in = scan_addr_ff + CNT_W'(1);
            rvalid_in    = 1'b1;
         end else begin
            rvalid_in = 1'b0;
         end
         if (rvalid_ff) begin
            if (pair_ok) begin
               have_cur_in = 1'b0;
               if (pairs_ff != PAIR_MAX) begin
                  pairs_in = pairs_ff + PAIR_W'(1);
               end
            end else begin
               cur_in      = ram_rdata;
               have_cur_in = 1'b1;
            end
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_pairs_in = pairs_ff;
         rsp_ovf_in   = ovf_ff;
         count_in     = '0;
         ovf_in       = 1'b0;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      j_ff         <= j_in;
      scan_addr_ff <= scan_addr_in;
      cur_ff       <= cur_in;
      have_cur_ff  <= have_cur_in;
      pairs_ff     <= pairs_in;
      rsp_pairs_ff <= rsp_pairs_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   stpc_ram #(
      .WIDTH (LENGTH_BITS),
      .DEPTH (MAX_STICKS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_pairs_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("stick count beyond buffer capacity");

   a_shift_walks_down: assert property (@(posedge clock) disable iff (reset)
      cmd.shift && !sts.shift_done |=> j_ff == $past(j_ff) - AW'(1))
      else $error("insertion position did not step down");

   a_ovf_only_when_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(cmd.accept && count_ff == COUNT_FULL))
      else $error("overflow set without a dropped stick");

   a_finish_clears_set: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && count_ff == '0 && !ovf_ff)
      else $error("result load did not clear the set");

endmodule

`default_nettype wire

// File: rtl/sorted_tolerance_pair_counter_unit.sv
// The first stick of a set is written straight into the buffer; any later stick is inserted
// into the sorted buffer, one shift per cycle for each stored stick larger than it.
// A last stick then starts a scan of the stored sticks over the memory read port, followed
// by the load of the result register; a pending result only stalls that final load.
// A new stick is accepted only in the idle state, once the previous insertion is done.
// Reset: synchronous, active high; clears set, flags, result valid and max_diff.
`default_nettype none

module sorted_tolerance_pair_counter_unit import stpc_pkg::*; #(
   parameter int MAX_STICKS  = 64,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   stpc_req_if.sink                   req_chan,
   stpc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [MAX_DIFF_W-1:0] max_diff_ff, max_diff_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  csr_write;

   stpc_cmd_type cmd;
   stpc_sts_type sts;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_diff_in = max_diff_ff;
      if (csr_write && (reg_idx == REG_IDX_MAX_DIFF)) begin
         max_diff_in = csr_pwdata[MAX_DIFF_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_IDX_MAX_DIFF) begin
         csr_prdata = CSR_DATA_W'(max_diff_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_ff <= '0;
      end else begin
         max_diff_ff <= max_diff_in;
      end
   end

   stpc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_last_stick (req_chan.last_stick),
      .req_ready      (req_chan.ready),
      .sts            (sts),
      .cmd            (cmd)
   );

   stpc_dp #(
      .MAX_STICKS  (MAX_STICKS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_stick_length (req_chan.stick_length),
      .max_diff         (max_diff_ff),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_pair_count   (rsp_chan.pair_count),
      .rsp_overflow     (rsp_chan.overflow)
   );

endmodule

`default_nettype wire
